[hdl/sha256_stream_hasher_unit_assert.svh]
// assertion macros used by the checker file of the hasher
`ifndef SHA256_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA256_STREAM_HASHER_UNIT_ASSERT_SVH

// clocked check, quiet while reset is applied
`define SHS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define SHS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/shs_pkg.sv]
// constants, tables and round functions of the sha-256 stream hasher
`timescale 1ns / 1ps

package shs_pkg;

  localparam int unsigned DIGEST_PARTS = 4;
  localparam int unsigned PART_IDX_W   = 2;
  localparam logic [PART_IDX_W-1:0] PART_LAST_IDX = PART_IDX_W'(DIGEST_PARTS - 1);

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  localparam logic [5:0] LEN_OFFSET    = 6'd56;
  localparam logic [5:0] FILL_LAST     = 6'd63;
  localparam logic [5:0] ROUND_LAST    = 6'd63;

  // initial hash words
  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // round constants
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr32(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] v);
    return rotr32(v, 2) ^ rotr32(v, 13) ^ rotr32(v, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] v);
    return rotr32(v, 6) ^ rotr32(v, 11) ^ rotr32(v, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] v);
    return rotr32(v, 7) ^ rotr32(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] v);
    return rotr32(v, 17) ^ rotr32(v, 19) ^ (v >> 10);
  endfunction

endpackage

[hdl/sha256_stream_hasher_unit.sv]
// top level of the sha-256 stream hasher: byte packer, padder, round unit
`timescale 1ns / 1ps

// Input channel (in_*): one message byte per transaction. in_final_item closes
// the message; in_no_byte marks a transaction without a byte, so a lone final
// transaction with in_no_byte set hashes the empty message.
// Result channel (out_*): after a final transaction four transactions carry the
// digest, most significant 64-bit word first, part_last on the fourth.
// Bytes are taken while in_stall is low. The 64th byte of a block starts
// the compression: one round per cycle through a single round unit, 64 rounds,
// then a fold into the chain value. in_stall is high while the round unit,
// the padder or the digest output is busy.
// Closing a message: the padder places one byte per cycle (0x80, zeros up to
// offset 56, then 8 length bytes), with one or two compressions, then the digest
// words follow.
// Reset (rst_n low at a clock edge) loads the initial hash words and empties the
// block. While out_stall is high the current digest word holds and nothing else
// moves.
module sha256_stream_hasher_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_msg_byte,
  input  logic                               in_final_item,
  input  logic                               in_no_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [63:0]                        out_digest_part,
  output logic [shs_pkg::PART_IDX_W-1:0]     out_part_index,
  output logic                               out_part_last
);
  import shs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_ZERO,
    ST_LEN,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [5:0]              fill_r, fill_nxt;
  logic [60:0]             bytes_r, bytes_nxt;
  logic [63:0]             bits_r, bits_nxt;
  logic [5:0]              round_r, round_nxt;
  logic [PART_IDX_W-1:0]   part_r, part_nxt;
  logic                    fin_r, fin_nxt;
  logic                    mark_done_r, mark_done_nxt;
  logic                    len_done_r, len_done_nxt;
  logic [31:0]             chain_r [8];
  logic [31:0]             chain_nxt [8];
  logic [31:0]             var_r [8];
  logic [31:0]             var_nxt [8];
  logic [511:0]            blk_r, blk_nxt;

  logic                    place_en;
  logic [7:0]              place_val;
  logic                    block_full;
  logic [31:0]             w_new;
  logic [31:0]             t1;
  logic [31:0]             t2;
  logic [2:0]              iv_sel;

  // message schedule: oldest word sits at the top of the block shift line
  assign w_new = small_sigma1(blk_r[63:32]) + blk_r[223:192]
               + small_sigma0(blk_r[479:448]) + blk_r[511:480];

  // shared round unit
  assign t1 = var_r[7] + big_sigma1(var_r[4])
            + ((var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6]))
            + ROUND_K[round_r] + blk_r[511:480];
  assign t2 = big_sigma0(var_r[0])
            + ((var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]));

  assign iv_sel     = {part_r, 1'b0};
  assign block_full = place_en && (fill_r == FILL_LAST);

  // sequencer and byte packer
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    bytes_nxt     = bytes_r;
    bits_nxt      = bits_r;
    round_nxt     = round_r;
    part_nxt      = part_r;
    fin_nxt       = fin_r;
    mark_done_nxt = mark_done_r;
    len_done_nxt  = len_done_r;
    chain_nxt     = chain_r;
    place_en      = 1'b0;
    place_val     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          fin_nxt = in_final_item;
          if (!in_no_byte) begin
            place_en  = 1'b1;
            place_val = in_msg_byte;
            bytes_nxt = bytes_r + 61'd1;
          end
          if (!in_no_byte && fill_r == FILL_LAST) begin
            state_nxt = ST_ROUND;
          end else if (in_final_item) begin
            state_nxt = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        place_en      = 1'b1;
        place_val     = PAD_MARK_BYTE;
        mark_done_nxt = 1'b1;
        bits_nxt      = {bytes_r, 3'b000};
        state_nxt     = (fill_r == FILL_LAST) ? ST_ROUND : ST_ZERO;
      end
      ST_ZERO: begin
        if (fill_r == LEN_OFFSET) begin
          state_nxt = ST_LEN;
        end else begin
          place_en = 1'b1;
          if (fill_r == FILL_LAST) begin
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_LEN: begin
        place_en  = 1'b1;
        place_val = bits_r[63:56];
        bits_nxt  = {bits_r[55:0], 8'h00};
        if (fill_r == FILL_LAST) begin
          len_done_nxt = 1'b1;
          state_nxt    = ST_ROUND;
        end
      end
      ST_ROUND: begin
        round_nxt = round_r + 6'd1;
        if (round_r == ROUND_LAST) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + var_r[i];
        end
        priority if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (!mark_done_r) begin
          state_nxt = ST_MARK;
        end else if (!len_done_r) begin
          state_nxt = ST_ZERO;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          // shift the digest out two words at a time, refill with the initial words
          for (int i = 0; i < 6; i++) begin
            chain_nxt[i] = chain_r[i + 2];
          end
          chain_nxt[6] = HASH_IV[iv_sel];
          chain_nxt[7] = HASH_IV[iv_sel + 3'd1];
          part_nxt     = part_r + PART_IDX_W'(1);
          if (part_r == PART_LAST_IDX) begin
            state_nxt     = ST_IDLE;
            fin_nxt       = 1'b0;
            mark_done_nxt = 1'b0;
            len_done_nxt  = 1'b0;
            bytes_nxt     = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (place_en) begin
      fill_nxt = fill_r + 6'd1;
    end
  end

  // block shift line and working variables
  always_comb begin
    blk_nxt = blk_r;
    var_nxt = var_r;
    if (place_en) begin
      blk_nxt = {blk_r[503:0], place_val};
    end else if (state_r == ST_ROUND) begin
      blk_nxt = {blk_r[479:0], w_new};
    end
    if (block_full) begin
      var_nxt = chain_r;
    end else if (state_r == ST_ROUND) begin
      var_nxt[7] = var_r[6];
      var_nxt[6] = var_r[5];
      var_nxt[5] = var_r[4];
      var_nxt[4] = var_r[3] + t1;
      var_nxt[3] = var_r[2];
      var_nxt[2] = var_r[1];
      var_nxt[1] = var_r[0];
      var_nxt[0] = t1 + t2;
    end
  end

  // control state and chain value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      bytes_r     <= '0;
      bits_r      <= '0;
      round_r     <= '0;
      part_r      <= '0;
      fin_r       <= 1'b0;
      mark_done_r <= 1'b0;
      len_done_r  <= 1'b0;
      chain_r     <= HASH_IV;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      bytes_r     <= bytes_nxt;
      bits_r      <= bits_nxt;
      round_r     <= round_nxt;
      part_r      <= part_nxt;
      fin_r       <= fin_nxt;
      mark_done_r <= mark_done_nxt;
      len_done_r  <= len_done_nxt;
      chain_r     <= chain_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    var_r <= var_nxt;
  end

  // ports
  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign out_digest_part = {chain_r[0], chain_r[1]};
  assign out_part_index  = part_r;
  assign out_part_last   = (part_r == PART_LAST_IDX);

endmodule

[hdl/shs_checker.sv]
// port-level checker for the sha-256 stream hasher, bound to the top level
`timescale 1ns / 1ps
`include "sha256_stream_hasher_unit_assert.svh"

module shs_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [7:0]                     in_msg_byte,
  input logic                           in_final_item,
  input logic                           in_no_byte,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [63:0]                    out_digest_part,
  input logic [shs_pkg::PART_IDX_W-1:0] out_part_index,
  input logic                           out_part_last
);
  import shs_pkg::*;

  // no input transaction is taken while the digest is being delivered
  `SHS_ASSERT(a_busy_while_out, out_valid |-> in_stall, "input taken during digest output")

  // digest words come in order
  `SHS_ASSERT(a_part_order, (out_valid && !out_stall && !out_part_last) |=> (out_valid && out_part_index == PART_IDX_W'($past(out_part_index) + PART_IDX_W'(1))), "digest words out of order")

  // last flag marks the fourth word
  `SHS_ASSERT_ALWAYS(a_last_flag, out_valid |-> (out_part_last == (out_part_index == PART_LAST_IDX)), "part_last on the wrong word")

  // an empty, non-final transaction leaves the unit ready
  `SHS_ASSERT(a_empty_item, (in_valid && !in_stall && in_no_byte && !in_final_item) |=> !in_stall, "empty transaction made the unit busy")

  // a stalled digest word holds
  `SHS_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_digest_part)), "stalled digest word changed")

endmodule

bind sha256_stream_hasher_unit shs_checker u_shs_checker (.*);

[tb/tb_sha256_stream_hasher_unit.sv]
// testbench of the sha-256 stream hasher: byte stream in, digest words checked against a model
`timescale 1ns / 1ps

module tb_sha256_stream_hasher_unit;

  localparam int N_PARTS     = 4;
  localparam int HOLD_CYCLES = 700;
  localparam int TAIL_CYCLES = 250;

  // sha-256 round constants and initial hash words
  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [7:0] PAD_START = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'd56;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       final_item;
    logic       no_byte;
  } byte_item_t;

  typedef struct packed {
    logic [63:0]                    part;
    logic [shs_pkg::PART_IDX_W-1:0] idx;
    logic                           last;
  } digest_word_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                               in_valid      = 1'b0;
  logic                               in_stall;
  logic [7:0]                         in_msg_byte   = 8'h00;
  logic                               in_final_item = 1'b0;
  logic                               in_no_byte    = 1'b0;
  logic                               out_valid;
  logic                               out_stall     = 1'b0;
  logic [63:0]                        out_digest_part;
  logic [shs_pkg::PART_IDX_W-1:0]     out_part_index;
  logic                               out_part_last;

  byte_item_t   byte_item_q [$];
  digest_word_t pending_digest_q [$];
  byte_item_t   drv_item;
  digest_word_t got_word;

  int  send_gap_pct  = 0;
  int  out_stall_pct = 0;
  int  err_cnt       = 0;
  bit  in_taken      = 1'b0;
  bit  hold_go       = 1'b0;
  bit  hold_on       = 1'b0;

  // model state
  logic [31:0] hash_h [8];
  logic [31:0] blk_w [16];
  logic [5:0]  blk_fill;
  logic [60:0] msg_len;

  sha256_stream_hasher_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_msg_byte     (in_msg_byte),
    .in_final_item   (in_final_item),
    .in_no_byte      (in_no_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_part (out_digest_part),
    .out_part_index  (out_part_index),
    .out_part_last   (out_part_last)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one 64-round compression of the current block into the chain
  task automatic sha_compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = blk_w[i];
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_h[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + w[r];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] = hash_h[i] + v[i];
  endtask

  // big-endian byte packing, compress on a full block
  task automatic sha_absorb(input logic [7:0] b);
    logic [31:0] sh;
    sh = (3 - blk_fill[1:0]) * 8;
    if (blk_fill[1:0] == 2'd0) blk_w[blk_fill[5:2]] = {24'h0, b} << sh;
    else blk_w[blk_fill[5:2]] = blk_w[blk_fill[5:2]] | ({24'h0, b} << sh);
    blk_fill = blk_fill + 6'd1;
    if (blk_fill == 6'd0) sha_compress();
  endtask

  task automatic sha_restart();
    for (int i = 0; i < 8; i++) hash_h[i] = SHA_H0[i];
    blk_fill = '0;
    msg_len  = '0;
  endtask

  // predict the digest words caused by one accepted transaction
  task automatic sha_take_item(input byte_item_t it);
    logic [63:0]  bit_len;
    digest_word_t dw;
    if (!it.no_byte) begin
      sha_absorb(it.msg_byte);
      msg_len = msg_len + 61'd1;
    end
    if (it.final_item) begin
      bit_len = {msg_len, 3'b000};
      sha_absorb(PAD_START);
      while (blk_fill != LEN_POS) sha_absorb(8'h00);
      for (int k = 7; k >= 0; k--) sha_absorb(bit_len[k*8 +: 8]);
      for (int k = 0; k < N_PARTS; k++) begin
        dw.part = {hash_h[2*k], hash_h[2*k+1]};
        dw.idx  = k[shs_pkg::PART_IDX_W-1:0];
        dw.last = (k == N_PARTS - 1);
        pending_digest_q = {pending_digest_q, dw};
      end
      sha_restart();
    end
  endtask

  task automatic push_item(input logic [7:0] b, input logic fin, input logic nob);
    byte_item_t it;
    it.msg_byte   = b;
    it.final_item = fin;
    it.no_byte    = nob;
    byte_item_q = {byte_item_q, it};
  endtask

  // random messages, mostly short, some around the padding and block boundaries
  task automatic queue_messages(input int n_items);
    int edge_len [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
    int cnt;
    int len;
    bit close_sep;
    cnt = 0;
    while (cnt < n_items) begin
      if ($urandom_range(99) < 15) len = edge_len[$urandom_range(7)];
      else len = $urandom_range(20);
      if (len > n_items - cnt) len = n_items - cnt;
      close_sep = (len == 0) || ($urandom_range(1) == 1);
      for (int i = 0; i < len; i++) begin
        // stray transaction without a byte, ignored by the block
        if ($urandom_range(99) < 4) begin
          push_item(8'($urandom_range(255)), 1'b0, 1'b1);
          cnt++;
        end
        push_item(8'($urandom_range(255)), (!close_sep && i == len - 1), 1'b0);
      end
      if (close_sep) push_item(8'($urandom_range(255)), 1'b1, 1'b1);
      cnt += len + (close_sep ? 1 : 0);
    end
  endtask

  task automatic wait_drained();
    while (byte_item_q.size() != 0 || in_valid || pending_digest_q.size() != 0)
      @(posedge clk);
  endtask

  // input transaction sampling and prediction
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) sha_take_item('{in_msg_byte, in_final_item, in_no_byte});
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (byte_item_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        drv_item = byte_item_q.pop_front();
        in_valid      <= 1'b1;
        in_msg_byte   <= drv_item.msg_byte;
        in_final_item <= drv_item.final_item;
        in_no_byte    <= drv_item.no_byte;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall driver
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_on || ($urandom_range(99) < out_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_digest_q.size() == 0) begin
        $error("unexpected digest word %h index %0d", out_digest_part, out_part_index);
        err_cnt++;
      end else begin
        got_word = pending_digest_q.pop_front();
        if (out_digest_part !== got_word.part) begin
          $error("digest_part: expected %h, got %h", got_word.part, out_digest_part);
          err_cnt++;
        end
        if (out_part_index !== got_word.idx) begin
          $error("part_index: expected %0d, got %0d", got_word.idx, out_part_index);
          err_cnt++;
        end
        if (out_part_last !== got_word.last) begin
          $error("part_last: expected %0d, got %0d", got_word.last, out_part_last);
          err_cnt++;
        end
      end
    end
  end

  // long receiver hold-off so the block backs up onto its input
  initial begin
    wait (hold_go);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // stimulus and phases
  initial begin
    sha_restart();
    for (int i = 0; i < 16; i++) blk_w[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty message, final with a byte, ignored item, byte extremes
    push_item(8'hff, 1'b1, 1'b1);
    push_item(8'h61, 1'b0, 1'b0);
    push_item(8'h62, 1'b0, 1'b0);
    push_item(8'h63, 1'b1, 1'b0);
    push_item(8'h5a, 1'b0, 1'b1);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'hff, 1'b0, 1'b0);
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'hff, 1'b1, 1'b0);
    push_item(8'h00, 1'b1, 1'b0);
    wait_drained();

    // no idling, with the long receiver hold-off
    queue_messages(80);
    hold_go = 1'b1;
    wait_drained();
    while (hold_on) @(posedge clk);

    // sender mostly idle
    send_gap_pct  = 85;
    out_stall_pct = 0;
    queue_messages(80);
    wait_drained();

    // receiver mostly stalling
    send_gap_pct  = 0;
    out_stall_pct = 85;
    queue_messages(80);
    wait_drained();

    // both idling
    send_gap_pct  = 34;
    out_stall_pct = 34;
    queue_messages(80);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_digest_q.size() != 0) begin
      $error("%0d digest words never arrived", pending_digest_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
